/* design/rgs_pkg.sv */
`timescale 1ns / 1ps

package rgs_pkg;

  localparam int FUNC_W  = 2;
  localparam int MS_W    = 16;
  localparam int IDX_W   = 4;
  localparam int COLOR_W = 8;
  localparam int TOTAL_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 2'd0,
    FN_WRITE = 2'd1,
    FN_START = 2'd2,
    FN_STOP  = 2'd3
  } func_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [MS_W-1:0]    dur;
  } step_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       rd_tgt;
    logic       div_init;
    logic       div_step;
    logic       acc;
    logic       from_ld;
    logic       to_ld;
    logic       sq_ld;
    logic       cu_ld;
    logic       ease_ld;
    logic [2:0] blend_ld;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_go;
    logic div_skip;
    logic div_done;
  } dp_stat_t;

endpackage

/* design/rgs_ctrl.sv */
`timescale 1ns / 1ps

module rgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rgs_pkg::dp_stat_t stat,
  output rgs_pkg::dp_cmd_t  cmd
);
  import rgs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'h0001,
    S_RDDUR   = 14'h0002,
    S_DIVINIT = 14'h0004,
    S_DIV     = 14'h0008,
    S_ACC     = 14'h0010,
    S_RDFROM  = 14'h0020,
    S_RDTO    = 14'h0040,
    S_SQ      = 14'h0080,
    S_CU      = 14'h0100,
    S_EASE    = 14'h0200,
    S_BLR     = 14'h0400,
    S_BLG     = 14'h0800,
    S_BLB     = 14'h1000,
    S_OUT     = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    cmd.take   = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.tick_go ? S_RDDUR : S_OUT;
        end
      end
      S_RDDUR: begin
        state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = stat.div_skip ? S_ACC : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_RDFROM;
      end
      S_RDFROM: begin
        state_next = S_RDTO;
      end
      S_RDTO: begin
        cmd.rd_tgt  = 1'b1;
        cmd.from_ld = 1'b1;
        state_next  = S_SQ;
      end
      S_SQ: begin
        cmd.to_ld  = 1'b1;
        cmd.sq_ld  = 1'b1;
        state_next = S_CU;
      end
      S_CU: begin
        cmd.cu_ld  = 1'b1;
        state_next = S_EASE;
      end
      S_EASE: begin
        cmd.ease_ld = 1'b1;
        state_next  = S_BLR;
      end
      S_BLR: begin
        cmd.blend_ld[0] = 1'b1;
        state_next      = S_BLG;
      end
      S_BLG: begin
        cmd.blend_ld[1] = 1'b1;
        state_next      = S_BLB;
      end
      S_BLB: begin
        cmd.blend_ld[2] = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/rgs_dp.sv */
`timescale 1ns / 1ps

module rgs_dp #(
  parameter int MAX_STEPS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rgs_pkg::dp_cmd_t             cmd,
  output rgs_pkg::dp_stat_t            stat,
  input  logic [rgs_pkg::FUNC_W-1:0]   func,
  input  logic [rgs_pkg::MS_W-1:0]     elapsed_ms,
  input  logic [rgs_pkg::IDX_W-1:0]    entry_index,
  input  logic [rgs_pkg::COLOR_W-1:0]  red_in,
  input  logic [rgs_pkg::COLOR_W-1:0]  green_in,
  input  logic [rgs_pkg::COLOR_W-1:0]  blue_in,
  input  logic [rgs_pkg::MS_W-1:0]     duration_ms,
  input  logic [rgs_pkg::TOTAL_W-1:0]  step_total,
  output logic [rgs_pkg::COLOR_W-1:0]  red_duty,
  output logic [rgs_pkg::COLOR_W-1:0]  green_duty,
  output logic [rgs_pkg::COLOR_W-1:0]  blue_duty,
  output logic                         running,
  output logic [rgs_pkg::IDX_W-1:0]    from_step,
  output logic [rgs_pkg::IDX_W-1:0]    to_step
);
  import rgs_pkg::*;

  localparam int IW   = $clog2(MAX_STEPS);
  localparam int CW   = $clog2(MAX_STEPS + 1);
  localparam int PW   = FRAC_BITS + 1;
  localparam int CNTW = $clog2(FRAC_BITS + 1);
  localparam int VW   = FRAC_BITS + COLOR_W + 2;
  localparam logic [PW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  func_t fn;

  // step table
  step_t          mem [MAX_STEPS];
  step_t          rd_data;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  waddr;

  // sequencer state
  logic [CW-1:0]      count;
  logic [CW-1:0]      cnt_new;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      tgt;
  logic [PW-1:0]      prog;
  logic               active;
  logic [COLOR_W-1:0] shown_r;
  logic [COLOR_W-1:0] shown_g;
  logic [COLOR_W-1:0] shown_b;

  // divider
  logic [MS_W-1:0] elapsed;
  logic [MS_W-1:0] dvsr;
  logic [MS_W:0]   rem;
  logic [MS_W:0]   shifted;
  logic            nbit;
  logic            fits;
  logic [CNTW-1:0] div_cnt;
  logic [PW-1:0]   quo;

  // progress update
  logic [PW:0]   sum;
  logic [PW-1:0] sat;
  logic [IW:0]   tgt_inc;
  logic          wrap;

  // easing
  step_t               from_e;
  step_t               to_e;
  logic                t_lo;
  logic [PW:0]         u_full;
  logic [PW-1:0]       x;
  logic [PW-1:0]       mul_a;
  logic [2*PW-1:0]     prod;
  logic [PW-1:0]       sq;
  logic [PW-1:0]       cu;
  logic [PW+1:0]       lo_e;
  logic [FRAC_BITS-1:0] e_lo;
  logic [PW-1:0]       half;
  logic [PW-1:0]       hi_diff;
  logic [FRAC_BITS-1:0] e_hi;
  logic [FRAC_BITS-1:0] ease;

  // blend
  logic [COLOR_W-1:0]        a_c;
  logic [COLOR_W-1:0]        b_c;
  logic signed [COLOR_W:0]   bdiff;
  logic signed [VW-1:0]      bprod;
  logic signed [VW-1:0]      vsum;
  logic [COLOR_W-1:0]        blend_out;

  assign fn      = func_t'(func);
  assign waddr   = IW'(entry_index);
  assign rd_addr = cmd.rd_tgt ? tgt : cur;
  assign cnt_new = (int'(step_total) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(step_total);

  assign stat.tick_go  = (fn == FN_TICK) && active && (count >= CW'(2));
  assign stat.div_skip = (rd_data.dur == '0) || ({1'b0, elapsed} >= {rd_data.dur, 1'b0});
  assign stat.div_done = (div_cnt == '0);

  // one quotient bit per cycle
  assign shifted = {rem[MS_W-1:0], nbit};
  assign fits    = (shifted >= {1'b0, dvsr});

  assign sum     = {1'b0, prog} + {1'b0, quo};
  assign sat     = sum[PW] ? '1 : sum[PW-1:0];
  assign tgt_inc = {1'b0, tgt} + (IW+1)'(1);
  assign wrap    = (tgt_inc == (IW+1)'(count));

  assign t_lo   = ~prog[FRAC_BITS-1];
  assign u_full = {1'b1, {PW{1'b0}}} - {1'b0, prog[FRAC_BITS-1:0], 1'b0};
  assign x      = t_lo ? prog : u_full[PW-1:0];
  assign mul_a  = cmd.cu_ld ? sq : x;
  assign prod   = mul_a * x;

  assign lo_e    = {cu, 2'b00};
  assign e_lo    = (lo_e >= (PW+2)'(ONE_Q)) ? '1 : lo_e[FRAC_BITS-1:0];
  assign half    = {1'b0, cu[PW-1:1]};
  assign hi_diff = ONE_Q - half;

  always_comb begin
    if (half >= ONE_Q) begin
      e_hi = '0;
    end else if (hi_diff[FRAC_BITS]) begin
      e_hi = '1;
    end else begin
      e_hi = hi_diff[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    if (cmd.blend_ld[1]) begin
      a_c = from_e.green;
      b_c = to_e.green;
    end else if (cmd.blend_ld[2]) begin
      a_c = from_e.blue;
      b_c = to_e.blue;
    end else begin
      a_c = from_e.red;
      b_c = to_e.red;
    end
  end

  // a + (b - a) * e, one channel per cycle
  assign bdiff     = $signed({1'b0, b_c}) - $signed({1'b0, a_c});
  assign bprod     = bdiff * $signed({1'b0, ease});
  assign vsum      = $signed({2'b00, a_c, {FRAC_BITS{1'b0}}}) + bprod;
  assign blend_out = vsum[FRAC_BITS +: COLOR_W];

  always_ff @(posedge clk) begin
    if (cmd.take && (fn == FN_WRITE) && (int'(entry_index) < MAX_STEPS)) begin
      mem[waddr] <= {red_in, green_in, blue_in, duration_ms};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur     <= '0;
      tgt     <= '0;
      prog    <= '0;
      active  <= 1'b0;
      shown_r <= '0;
      shown_g <= '0;
      shown_b <= '0;
    end else begin
      if (cmd.take) begin
        unique case (fn)
          FN_START: begin
            count <= cnt_new;
            if (cnt_new >= CW'(2)) begin
              cur    <= '0;
              tgt    <= IW'(1);
              prog   <= '0;
              active <= 1'b1;
            end
          end
          FN_STOP: begin
            active  <= 1'b0;
            shown_r <= '0;
            shown_g <= '0;
            shown_b <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.acc) begin
        if (sat[FRAC_BITS]) begin
          prog <= '0;
          cur  <= tgt;
          tgt  <= wrap ? '0 : tgt_inc[IW-1:0];
        end else begin
          prog <= sat;
        end
      end
      if (cmd.blend_ld[0]) begin
        shown_r <= blend_out;
      end
      if (cmd.blend_ld[1]) begin
        shown_g <= blend_out;
      end
      if (cmd.blend_ld[2]) begin
        shown_b <= blend_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      elapsed <= elapsed_ms;
    end
    // quo preset to all ones covers the saturated case
    if (cmd.div_init) begin
      dvsr    <= rd_data.dur;
      rem     <= {2'b00, elapsed[MS_W-1:1]};
      nbit    <= elapsed[0];
      div_cnt <= CNTW'(FRAC_BITS);
      quo     <= '1;
    end
    if (cmd.div_step) begin
      rem     <= fits ? (shifted - {1'b0, dvsr}) : shifted;
      quo     <= {quo[PW-2:0], fits};
      nbit    <= 1'b0;
      div_cnt <= div_cnt - CNTW'(1);
    end
    if (cmd.from_ld) begin
      from_e <= rd_data;
    end
    if (cmd.to_ld) begin
      to_e <= rd_data;
    end
    if (cmd.sq_ld) begin
      sq <= prod[FRAC_BITS +: PW];
    end
    if (cmd.cu_ld) begin
      cu <= prod[FRAC_BITS +: PW];
    end
    if (cmd.ease_ld) begin
      ease <= t_lo ? e_lo : e_hi;
    end
  end

  assign red_duty   = shown_r;
  assign green_duty = shown_g;
  assign blue_duty  = shown_b;
  assign running    = active;
  assign from_step  = IDX_W'(cur);
  assign to_step    = IDX_W'(tgt);

endmodule

/* design/rgb_gradient_sequencer.sv */
`timescale 1ns / 1ps
// rgb_gradient_sequencer: fades an RGB LED through a table of color steps
// with cubic ease-in-out.
// Input channel (in_valid / in_ready) carries one item: func selects tick,
// write step entry, start with step_total steps, or stop. Every item gives
// exactly one result on the output channel (out_valid / out_ready): the
// shown duty per color, running, and the from / to step indexes.
// Write, start, stop and idle ticks: the result is valid in the cycle
// after the item is taken.
// Active tick: a table read of the duration, then a bit-serial divider
// giving FRAC_BITS + 1 quotient bits for the progress increment, then
// table reads, two multiplies for the easing and one blend state per
// color. The divider is skipped for a zero duration or a saturated
// increment.
// One item is in flight at a time; the next item is taken in the cycle
// after its result is taken.
// While out_ready is low the result holds and no item is taken.
// Reset clears count, indexes, progress and the LED; the step table is
// not cleared and must be written before it is used.

module rgb_gradient_sequencer #(
  parameter int MAX_STEPS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgs_pkg::FUNC_W-1:0]   func,
  input  logic [rgs_pkg::MS_W-1:0]     elapsed_ms,
  input  logic [rgs_pkg::IDX_W-1:0]    entry_index,
  input  logic [rgs_pkg::COLOR_W-1:0]  red_in,
  input  logic [rgs_pkg::COLOR_W-1:0]  green_in,
  input  logic [rgs_pkg::COLOR_W-1:0]  blue_in,
  input  logic [rgs_pkg::MS_W-1:0]     duration_ms,
  input  logic [rgs_pkg::TOTAL_W-1:0]  step_total,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgs_pkg::COLOR_W-1:0]  red_duty,
  output logic [rgs_pkg::COLOR_W-1:0]  green_duty,
  output logic [rgs_pkg::COLOR_W-1:0]  blue_duty,
  output logic                         running,
  output logic [rgs_pkg::IDX_W-1:0]    from_step,
  output logic [rgs_pkg::IDX_W-1:0]    to_step
);
  import rgs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rgs_dp #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .elapsed_ms  (elapsed_ms),
    .entry_index (entry_index),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .duration_ms (duration_ms),
    .step_total  (step_total),
    .red_duty    (red_duty),
    .green_duty  (green_duty),
    .blue_duty   (blue_duty),
    .running     (running),
    .from_step   (from_step),
    .to_step     (to_step)
  );

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("item taken while a result is pending");

  a_short_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !stat.tick_go) |=> out_valid)
    else $error("short item result not ready in one cycle");

  a_stop_dark: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (func == FN_STOP)) |=>
      (!running && (red_duty == '0) && (green_duty == '0) && (blue_duty == '0)))
    else $error("stop did not turn the led off");

  a_run_by_start: assert property (@(posedge clk) disable iff (rst)
    $rose(running) |-> $past(in_valid && in_ready && (func == FN_START)))
    else $error("running set without a start item");

endmodule
